// File: hw/rtl/priority_ring_victim_select_unit_defines.svh
// Assertion macros shared by the checker of the priority ring victim select unit.
`ifndef PRIORITY_RING_VICTIM_SELECT_UNIT_DEFINES_SVH
`define PRIORITY_RING_VICTIM_SELECT_UNIT_DEFINES_SVH

// Check a consequence in the same cycle as its antecedent.
`define PRVS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("prvs check failed");

// Check a consequence in the cycle after its antecedent.
`define PRVS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("prvs check failed");

`endif

// File: hw/rtl/prvs_pkg.sv
// Package with payload types and request codes of the priority ring victim select unit.
package prvs_pkg;

  localparam logic [1:0] REQ_CHANGE = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_VICTIM = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [5:0] buffer_index;
    logic [2:0] new_level;
  } prvs_in_t;

  typedef struct packed {
    logic       found;
    logic [5:0] victim_index;
  } prvs_out_t;

endpackage

// File: hw/rtl/priority_ring_victim_select_unit.sv
// Top level: buffer ring bookkeeping and victim selection over one link memory.
// A request that changes nothing goes straight from ST_IDLE to ST_DONE; a move that unlinks a
// buffer and appends it to a non-empty ring passes ST_READ, ST_UNLNK, ST_LINK_B, ST_LINK_T,
// ST_LINK_H and ST_DONE. The single write port of the link memory takes up to five entry
// writes per request, one per cycle, and a new word is taken only once the last is done:
// in_ready is high only when the sequencer is idle. After reset a clearing pass marks
// every buffer in use; no word is accepted until it ends.
module priority_ring_victim_select_unit #(
  parameter int NUM_BUFFERS = 64,
  parameter int NUM_LEVELS  = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  prvs_pkg::prvs_in_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output prvs_pkg::prvs_out_t out_data
);
  import prvs_pkg::*;

  localparam int IDX_W = $clog2(NUM_BUFFERS);
  localparam int LVL_W = $clog2(NUM_LEVELS + 1);
  localparam int LIX_W = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
  // Level code that means "in use, in no ring".
  localparam logic [LVL_W-1:0] LVL_USE  = LVL_W'(NUM_LEVELS);
  localparam logic [IDX_W-1:0] CLR_LAST = IDX_W'(NUM_BUFFERS - 1);

  // One entry per buffer: ring successor, ring predecessor and level.
  typedef struct packed {
    logic [IDX_W-1:0] nxt;
    logic [IDX_W-1:0] prv;
    logic [LVL_W-1:0] lvl;
  } entry_t;

  // Sequencer states; each link memory write takes a state of its own.
  typedef enum logic [7:0] {
    ST_CLEAR  = 8'b0000_0001,  // sweep the memory after reset
    ST_IDLE   = 8'b0000_0010,  // take a word, issue the read of the addressed buffer
    ST_READ   = 8'b0000_0100,  // detach decision, patch successor's back link
    ST_UNLNK  = 8'b0000_1000,  // patch predecessor's forward link
    ST_LINK_B = 8'b0001_0000,  // write the buffer's own entry
    ST_LINK_T = 8'b0010_0000,  // old tail points forward to the buffer
    ST_LINK_H = 8'b0100_0000,  // head points back to the buffer
    ST_DONE   = 8'b1000_0000   // hand the result to the output register
  } state_t;

  state_t state_r, state_nxt;

  // Link memory: one write port with field enables, one registered read port.
  entry_t           link_mem [NUM_BUFFERS];
  entry_t           rd_data_r;
  logic             rd_en;
  logic [IDX_W-1:0] rd_addr;
  logic             we_nxt, we_prv, we_lvl;
  logic [IDX_W-1:0] wr_addr;
  entry_t           wr_data;

  // Ring heads and occupancy flags, one per level.
  logic [IDX_W-1:0]      ring_head_r   [NUM_LEVELS];
  logic [IDX_W-1:0]      ring_head_nxt [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] ring_ne_r, ring_ne_nxt;
  logic [NUM_LEVELS-1:0] head_is_b;
  logic [LIX_W-1:0]      head_ix;
  logic [IDX_W-1:0]      head_rd;

  // Per-request working registers.
  logic [IDX_W-1:0] clr_cnt_r, clr_cnt_nxt;
  logic [IDX_W-1:0] b_r, b_nxt;
  logic [LVL_W-1:0] lv_r, lv_nxt;
  logic [IDX_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] p_r, p_nxt;
  logic [IDX_W-1:0] h_r, h_nxt;
  logic [IDX_W-1:0] t_r, t_nxt;
  logic             det_r, det_nxt;
  logic             app_r, app_nxt;
  logic             res_found_r, res_found_nxt;
  logic [5:0]       res_idx_r, res_idx_nxt;

  logic      out_valid_r, out_valid_nxt;
  prvs_out_t out_data_r, out_data_nxt;

  // Decode helpers.
  logic             vic_hit;
  logic [LIX_W-1:0] vic_lvl;
  logic             idx_ok;
  logic             in_ring;
  logic             lone;
  logic             to_ring;
  logic [LIX_W-1:0] lvb_ix;
  logic [LIX_W-1:0] lv_ix;
  logic [IDX_W-1:0] t_fwd;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign lvb_ix  = LIX_W'(rd_data_r.lvl);
  assign lv_ix   = LIX_W'(lv_r);
  assign to_ring = (32'(lv_r) < NUM_LEVELS);
  assign in_ring = (32'(rd_data_r.lvl) < NUM_LEVELS);
  assign lone    = (rd_data_r.nxt == b_r);
  assign idx_ok  = (32'(in_data.buffer_index) < NUM_BUFFERS);

  // Lowest non-empty ring wins the victim search.
  always_comb begin
    vic_hit = 1'b0;
    vic_lvl = '0;
    for (int i = NUM_LEVELS - 1; i >= 0; i--) begin
      if (ring_ne_r[i]) begin
        vic_hit = 1'b1;
        vic_lvl = LIX_W'(i);
      end
    end
  end

  // Compare every head with the buffer in hand at its own place.
  always_comb begin
    for (int i = 0; i < NUM_LEVELS; i++) begin
      head_is_b[i] = (ring_head_r[i] == b_r);
    end
  end

  // Single read port of the head file: victim level while idle, target level otherwise.
  assign head_ix = (state_r == ST_IDLE) ? vic_lvl : lv_ix;
  assign head_rd = ring_head_r[head_ix];

  // Old tail of the target ring. The back link of the head may have been rewritten by the
  // detach at the very edge that read it: forward the predecessor in that case.
  assign t_fwd = (det_r && (h_r == n_r)) ? p_r : rd_data_r.prv;

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    b_nxt         = b_r;
    lv_nxt        = lv_r;
    n_nxt         = n_r;
    p_nxt         = p_r;
    h_nxt         = h_r;
    t_nxt         = t_r;
    det_nxt       = det_r;
    app_nxt       = app_r;
    res_found_nxt = res_found_r;
    res_idx_nxt   = res_idx_r;
    ring_ne_nxt   = ring_ne_r;
    ring_head_nxt = ring_head_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    rd_en   = 1'b0;
    rd_addr = b_r;
    we_nxt  = 1'b0;
    we_prv  = 1'b0;
    we_lvl  = 1'b0;
    wr_addr = b_r;
    wr_data = '{nxt: b_r, prv: b_r, lvl: lv_r};

    // Drop the result once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        // Mark every buffer in use; links stay meaningless until written.
        we_nxt  = 1'b1;
        we_prv  = 1'b1;
        we_lvl  = 1'b1;
        wr_addr = clr_cnt_r;
        wr_data = '{nxt: '0, prv: '0, lvl: LVL_USE};
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (clr_cnt_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_valid) begin
          res_found_nxt = 1'b0;
          res_idx_nxt   = '0;
          state_nxt     = ST_DONE;
          case (in_data.req_type)
            REQ_CHANGE, REQ_REMOVE: begin
              if (idx_ok) begin
                b_nxt = IDX_W'(in_data.buffer_index);
                if ((in_data.req_type == REQ_CHANGE) &&
                    (32'(in_data.new_level) < NUM_LEVELS)) begin
                  lv_nxt = LVL_W'(in_data.new_level);
                end else begin
                  lv_nxt = LVL_USE;
                end
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(in_data.buffer_index);
                state_nxt = ST_READ;
              end
            end
            REQ_VICTIM: begin
              if (vic_hit) begin
                b_nxt         = head_rd;
                lv_nxt        = LVL_USE;
                res_found_nxt = 1'b1;
                res_idx_nxt   = 6'(head_rd);
                rd_en         = 1'b1;
                rd_addr       = head_rd;
                state_nxt     = ST_READ;
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end

      ST_READ: begin
        // Detach from the current ring.
        n_nxt   = rd_data_r.nxt;
        p_nxt   = rd_data_r.prv;
        det_nxt = in_ring && !lone;
        if (in_ring && lone) begin
          ring_ne_nxt[lvb_ix] = 1'b0;
        end
        if (in_ring && !lone) begin
          we_prv      = 1'b1;
          wr_addr     = rd_data_r.nxt;
          wr_data.prv = rd_data_r.prv;
          if (head_is_b[lvb_ix]) begin
            ring_head_nxt[lvb_ix] = rd_data_r.nxt;
          end
        end
        // Append decision against the rings as they stand after the detach.
        app_nxt = to_ring && ring_ne_nxt[lv_ix];
        if (in_ring && !lone && (lvb_ix == lv_ix) && head_is_b[lvb_ix]) begin
          h_nxt = rd_data_r.nxt;
        end else begin
          h_nxt = head_rd;
        end
        if (to_ring && ring_ne_nxt[lv_ix]) begin
          rd_en   = 1'b1;
          rd_addr = h_nxt;
        end
        state_nxt = (in_ring && !lone) ? ST_UNLNK : ST_LINK_B;
      end

      ST_UNLNK: begin
        we_nxt      = 1'b1;
        wr_addr     = p_r;
        wr_data.nxt = n_r;
        state_nxt   = ST_LINK_B;
      end

      ST_LINK_B: begin
        wr_addr = b_r;
        if (!to_ring) begin
          // In use: level only, links left as they are.
          we_lvl      = 1'b1;
          wr_data.lvl = LVL_USE;
          state_nxt   = ST_DONE;
        end else if (!app_r) begin
          // Start a ring of one.
          we_nxt  = 1'b1;
          we_prv  = 1'b1;
          we_lvl  = 1'b1;
          wr_data = '{nxt: b_r, prv: b_r, lvl: lv_r};
          ring_head_nxt[lv_ix] = b_r;
          ring_ne_nxt[lv_ix]   = 1'b1;
          state_nxt            = ST_DONE;
        end else begin
          // Slot in between old tail and head.
          we_nxt    = 1'b1;
          we_prv    = 1'b1;
          we_lvl    = 1'b1;
          wr_data   = '{nxt: h_r, prv: t_fwd, lvl: lv_r};
          t_nxt     = t_fwd;
          state_nxt = ST_LINK_T;
        end
      end

      ST_LINK_T: begin
        we_nxt      = 1'b1;
        wr_addr     = t_r;
        wr_data.nxt = b_r;
        state_nxt   = ST_LINK_H;
      end

      ST_LINK_H: begin
        we_prv      = 1'b1;
        wr_addr     = h_r;
        wr_data.prv = b_r;
        state_nxt   = ST_DONE;
      end

      ST_DONE: begin
        // Hold the result until the output register is free.
        if (!out_valid_r || out_ready) begin
          out_valid_nxt             = 1'b1;
          out_data_nxt.found        = res_found_r;
          out_data_nxt.victim_index = res_idx_r;
          state_nxt                 = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Link memory.
  always_ff @(posedge clk) begin
    if (we_nxt) begin
      link_mem[wr_addr].nxt <= wr_data.nxt;
    end
    if (we_prv) begin
      link_mem[wr_addr].prv <= wr_data.prv;
    end
    if (we_lvl) begin
      link_mem[wr_addr].lvl <= wr_data.lvl;
    end
    if (rd_en) begin
      rd_data_r <= link_mem[rd_addr];
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      ring_ne_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      ring_ne_r   <= ring_ne_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    ring_head_r <= ring_head_nxt;
    b_r         <= b_nxt;
    lv_r        <= lv_nxt;
    n_r         <= n_nxt;
    p_r         <= p_nxt;
    h_r         <= h_nxt;
    t_r         <= t_nxt;
    det_r       <= det_nxt;
    app_r       <= app_nxt;
    res_found_r <= res_found_nxt;
    res_idx_r   <= res_idx_nxt;
    out_data_r  <= out_data_nxt;
  end

endmodule

// File: hw/rtl/prvs_checker.sv
// Port checker of the priority ring victim select unit and its bind.
`include "priority_ring_victim_select_unit_defines.svh"

module prvs_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input prvs_pkg::prvs_in_t  in_data,
  input logic                out_valid,
  input logic                out_ready,
  input prvs_pkg::prvs_out_t out_data
);
  import prvs_pkg::*;

  // A stalled result word stays offered.
  `PRVS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // A stalled result word keeps its payload.
  `PRVS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(out_data))
  // One word at a time: taking a request closes the input.
  `PRVS_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, in_valid && in_ready, !in_ready)
  // No victim means index zero.
  `PRVS_ASSERT_NOW(a_miss_zero, clk, rst_n, out_valid && !out_data.found,
                   out_data.victim_index == 6'd0)

endmodule

bind priority_ring_victim_select_unit prvs_checker u_prvs_checker (.*);
